FILE: src/rc4_pkg.sv
package rc4_pkg;

	// Size of the permutation and of the key store.
	localparam int unsigned PermSize      = 256;
	localparam int unsigned KeyStoreDepth = 256;
	localparam int unsigned LenW          = 9;
	localparam logic [LenW-1:0] KeyLenReset = 9'd16;

	// Item kinds on the input selector.
	localparam logic FUNC_KEY  = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_DATA_DONE  = 2'd0;
	localparam logic [1:0] ST_KEY_STORED = 2'd1;
	localparam logic [1:0] ST_SCHED_DONE = 2'd2;
	localparam logic [1:0] ST_NO_KEY     = 2'd3;

	// One input item as seen by the engine.
	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic       last;
	} rc4_req_t;

	// One result item from the engine.
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} rc4_res_t;

	// Key length limited to the key store depth, with zero counted as one.
	function automatic logic [LenW-1:0] eff_length(input logic [LenW-1:0] len);
		logic [LenW-1:0] r;
		r = len;
		if (len > LenW'(KeyStoreDepth)) begin
			r = LenW'(KeyStoreDepth);
		end
		if (len == '0) begin
			r = LenW'(1);
		end
		return r;
	endfunction

endpackage

FILE: src/rc4_stream_cipher_core.sv
// RC4 stream cipher, one byte per item.
// Input stream: s_tdata carries the byte, s_tuser selects a key byte (0) or a
// data byte (1), and s_tlast marks the final data byte of a message.
// Output stream: one result per input transfer. m_tdata is the data byte XOR
// keystream (zero for key bytes and refused data), m_tuser the status
// (0 data done, 1 key byte stored, 2 key schedule done, 3 no key yet), and
// m_tlast echoes s_tlast for data bytes.
// The cfg channel writes the key length in bytes; it is always ready. The user is
// to write it only while no item is in flight; the block does not enforce this.
// One item is worked at a time; s_tready is low until its result has moved
// into the output register. A data byte runs six sequencer steps around the
// shared adder and the permutation memory, with one write and one registered
// read per cycle; the last key byte runs the identity fill of all 256 entries,
// then the schedule steps S_KA to S_KD once for each entry.
// When the receiver stalls, the result waits in the output register and the
// engine holds its finished result until that register frees.
// Reset clears the indices, the key count and the keyed flag, and sets the
// key length to 16; the memories are not cleared.
module rc4_stream_cipher_core
	import rc4_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [LenW-1:0] cfg_data,   // key_length
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,    // byte_in
	input  logic            s_tuser,    // func
	input  logic            s_tlast,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,    // data_out
	output logic [1:0]      m_tuser,    // status
	output logic            m_tlast
);

	logic [LenW-1:0] key_len_q;
	rc4_req_t        req;
	rc4_res_t        res;
	logic            res_valid;
	logic            res_ready;
	logic            m_valid_q;
	rc4_res_t        m_res_q;

	assign cfg_ready = 1'b1;
	assign req       = '{func: s_tuser, data_byte: s_tdata, last: s_tlast};
	assign res_ready = !m_valid_q || m_tready;

	// Key length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= KeyLenReset;
		end else if (cfg_valid) begin
			key_len_q <= cfg_data;
		end
	end

	rc4_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.key_len   (key_len_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register; loads when empty or when the current transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_res_q.data;
	assign m_tuser  = m_res_q.status;
	assign m_tlast  = m_res_q.last;

endmodule

FILE: src/rc4_engine.sv
module rc4_engine
	import rc4_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  rc4_req_t        req,
	input  logic [LenW-1:0] key_len,
	output logic            res_valid,
	input  logic            res_ready,
	output rc4_res_t        res
);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_KA   = 4'd2;
	localparam logic [3:0] S_KB   = 4'd3;
	localparam logic [3:0] S_KC   = 4'd4;
	localparam logic [3:0] S_KD   = 4'd5;
	localparam logic [3:0] S_PA   = 4'd6;
	localparam logic [3:0] S_PB   = 4'd7;
	localparam logic [3:0] S_PC   = 4'd8;
	localparam logic [3:0] S_PD   = 4'd9;
	localparam logic [3:0] S_PE   = 4'd10;
	localparam logic [3:0] S_PF   = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0]      state_q;
	logic [7:0]      i_q;
	logic [7:0]      j_q;
	logic [7:0]      n_q;
	logic [7:0]      kidx_q;
	logic [LenW-1:0] kcnt_q;
	logic [LenW-1:0] len_q;
	logic            keyed_q;
	logic [7:0]      si_q;
	logic [7:0]      sj_q;
	logic [7:0]      byte_q;
	logic            last_q;
	rc4_res_t        res_q;

	// Memories and their ports.
	logic [7:0] perm_mem [PermSize];
	logic [7:0] key_mem  [KeyStoreDepth];
	logic       perm_we;
	logic [7:0] perm_waddr;
	logic [7:0] perm_wdata;
	logic [7:0] perm_raddr;
	logic [7:0] perm_rdata_q;
	logic       key_we;
	logic [7:0] key_rdata_q;

	// Shared three-input byte adder.
	logic [7:0] add_a;
	logic [7:0] add_b;
	logic [7:0] add_c;
	logic [7:0] add_sum;

	logic [LenW-1:0] kcnt_next;
	logic [LenW-1:0] len_eff;
	logic [LenW-1:0] kidx_next;

	assign add_sum   = add_a + add_b + add_c;
	assign kcnt_next = kcnt_q + LenW'(1);
	assign len_eff   = eff_length(key_len);
	assign kidx_next = {1'b0, kidx_q} + LenW'(1);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign key_we    = req_ready && req_valid && (req.func == FUNC_KEY) && !kcnt_q[LenW-1];

	// Adder operands and memory addresses per sequencer step.
	always_comb begin
		add_a      = '0;
		add_b      = '0;
		add_c      = '0;
		perm_raddr = n_q;
		perm_we    = 1'b0;
		perm_waddr = n_q;
		perm_wdata = n_q;
		unique case (state_q)
			S_INIT: begin
				perm_we = 1'b1;
			end
			S_KB: begin
				add_a      = j_q;
				add_b      = perm_rdata_q;
				add_c      = key_rdata_q;
				perm_raddr = add_sum;
			end
			S_KC: begin
				perm_we    = 1'b1;
				perm_wdata = perm_rdata_q;
			end
			S_KD: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			S_PA: begin
				add_a      = i_q;
				add_b      = 8'd1;
				perm_raddr = add_sum;
			end
			S_PB: begin
				add_a      = j_q;
				add_b      = perm_rdata_q;
				perm_raddr = add_sum;
			end
			S_PC: begin
				perm_we    = 1'b1;
				perm_waddr = i_q;
				perm_wdata = perm_rdata_q;
			end
			S_PD: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			S_PE: begin
				add_a      = si_q;
				add_b      = sj_q;
				perm_raddr = add_sum;
			end
			default: begin
			end
		endcase
	end

	// Permutation memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		perm_rdata_q <= perm_mem[perm_raddr];
	end

	// Key store: written on key transfers, read by the schedule.
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[kcnt_q[7:0]] <= req.data_byte;
		end
		key_rdata_q <= key_mem[kidx_q];
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			byte_q <= req.data_byte;
			last_q <= req.last;
			len_q  <= len_eff;
		end
		if (state_q == S_KB || state_q == S_PB) begin
			si_q <= perm_rdata_q;
		end
		if (state_q == S_PC) begin
			sj_q <= perm_rdata_q;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			kidx_q  <= '0;
			kcnt_q  <= '0;
			keyed_q <= 1'b0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.func == FUNC_KEY) begin
							if (kcnt_next >= len_eff) begin
								kcnt_q  <= '0;
								n_q     <= '0;
								state_q <= S_INIT;
							end else begin
								kcnt_q  <= kcnt_next;
								res_q   <= '{data: 8'd0, status: ST_KEY_STORED, last: 1'b0};
								state_q <= S_DONE;
							end
						end else if (!keyed_q) begin
							res_q   <= '{data: 8'd0, status: ST_NO_KEY, last: req.last};
							state_q <= S_DONE;
						end else begin
							state_q <= S_PA;
						end
					end
				end
				// Identity fill, one entry per cycle.
				S_INIT: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						j_q     <= '0;
						kidx_q  <= '0;
						state_q <= S_KA;
					end
				end
				S_KA: begin
					state_q <= S_KB;
				end
				// Accumulate the scrambling index and step the key index.
				S_KB: begin
					j_q <= add_sum;
					if (kidx_next == len_q) begin
						kidx_q <= '0;
					end else begin
						kidx_q <= kidx_next[7:0];
					end
					state_q <= S_KC;
				end
				S_KC: begin
					state_q <= S_KD;
				end
				S_KD: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
						res_q   <= '{data: 8'd0, status: ST_SCHED_DONE, last: 1'b0};
						state_q <= S_DONE;
					end else begin
						state_q <= S_KA;
					end
				end
				S_PA: begin
					i_q     <= add_sum;
					state_q <= S_PB;
				end
				S_PB: begin
					j_q     <= add_sum;
					state_q <= S_PC;
				end
				S_PC: begin
					state_q <= S_PD;
				end
				S_PD: begin
					state_q <= S_PE;
				end
				S_PE: begin
					state_q <= S_PF;
				end
				// Keystream byte is in the read register now.
				S_PF: begin
					res_q   <= '{data: byte_q ^ perm_rdata_q, status: ST_DATA_DONE,
						last: last_q};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: bench/tb_rc4_stream_cipher_core.sv
module tb_rc4_stream_cipher_core
	import rc4_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 12;
	localparam int TOTAL_ITEMS = 1300;
	localparam int SETTLE      = 8;
	localparam int CYCLE_LIMIT = 10000000;

	// Kinds of rows in the directed table.
	typedef enum logic {ROW_ITEM, ROW_KEYLEN} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic       func;
		logic [7:0] din;
		logic       lst;
		logic [8:0] len;
		logic       typed;
		rc4_res_t   want;
	} stim_row_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [LenW-1:0] cfg_data;
	logic            s_tvalid;
	logic            s_tready;
	logic [7:0]      s_tdata;
	logic            s_tuser;
	logic            s_tlast;
	logic            m_tvalid;
	logic            m_tready;
	logic [7:0]      m_tdata;
	logic [1:0]      m_tuser;
	logic            m_tlast;

	// Cipher state mirrored by the predictor.
	logic [7:0]      perm [256];
	logic [7:0]      kstore [256];
	logic [7:0]      ks_i;
	logic [7:0]      ks_j;
	logic [8:0]      kcount;
	logic            have_key;
	logic [8:0]      key_len;

	rc4_res_t        expected_res [$];
	stim_row_t       plan [$];
	int              errors;
	int              items_sent;
	int              cycles;
	int              stall_left;
	bit              quiet;

	rc4_stream_cipher_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Free-running clock.
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Key length as the block uses it: limited to the store, zero taken as one.
	function automatic logic [8:0] key_len_eff();
		logic [8:0] len;
		len = key_len;
		if (len > 9'd256) begin
			len = 9'd256;
		end
		if (len == 9'd0) begin
			len = 9'd1;
		end
		return len;
	endfunction

	// Idle length for either side: mostly none or short, a few long.
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Predicts the result of one input item and advances the mirrored state.
	task automatic rc4_predict(input logic func, input logic [7:0] din, input logic lst,
			output rc4_res_t res);
		logic [8:0] len;
		logic [7:0] acc;
		logic [7:0] tmp;
		logic [7:0] pos;
		int n;
		res = '0;
		if (func == FUNC_KEY) begin
			len = key_len_eff();
			if (kcount < 9'd256) begin
				kstore[kcount[7:0]] = din;
			end
			kcount = kcount + 9'd1;
			if (kcount >= len) begin
				// Key schedule: identity fill, then scramble with the key.
				for (n = 0; n < 256; n++) begin
					perm[n] = n[7:0];
				end
				acc = 8'd0;
				for (n = 0; n < 256; n++) begin
					acc = acc + perm[n] + kstore[n % len];
					tmp = perm[n];
					perm[n] = perm[acc];
					perm[acc] = tmp;
				end
				ks_i = 8'd0;
				ks_j = 8'd0;
				kcount = 9'd0;
				have_key = 1'b1;
				res.status = ST_SCHED_DONE;
			end else begin
				res.status = ST_KEY_STORED;
			end
		end else begin
			res.last = lst;
			if (!have_key) begin
				res.status = ST_NO_KEY;
			end else begin
				// One keystream step with swap.
				ks_i = ks_i + 8'd1;
				ks_j = ks_j + perm[ks_i];
				tmp = perm[ks_i];
				perm[ks_i] = perm[ks_j];
				perm[ks_j] = tmp;
				pos = perm[ks_i] + perm[ks_j];
				res.data = din ^ perm[pos];
				res.status = ST_DATA_DONE;
			end
		end
	endtask

	// Offers one item after a random gap and records its expected result on transfer.
	task automatic send_item(input logic func, input logic [7:0] din, input logic lst,
			input logic typed, input rc4_res_t want);
		rc4_res_t pred;
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= din;
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		rc4_predict(func, din, lst, pred);
		expected_res.push_back(typed ? want : pred);
		items_sent++;
	endtask

	task automatic send_random(input logic func, input logic lst);
		send_item(func, 8'($urandom), lst, 1'b0, '0);
	endtask

	// Holds the sender off until every expected result has arrived.
	task automatic wait_idle();
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
		end
		while (expected_res.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes the key length once the block is idle.
	task automatic write_key_len(input logic [8:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		key_len = value;
	endtask

	// Appends a directed item; the typed result applies only where typed is set.
	task automatic add_item(input logic func, input logic [7:0] din, input logic lst,
			input logic typed, input logic [1:0] status);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.func = func;
		row.din = din;
		row.lst = lst;
		row.len = '0;
		row.typed = typed;
		row.want.data = 8'd0;
		row.want.status = status;
		row.want.last = (func == FUNC_DATA) ? lst : 1'b0;
		plan.push_back(row);
	endtask

	task automatic add_keylen(input logic [8:0] value);
		stim_row_t row;
		row = '{kind: ROW_KEYLEN, func: 1'b0, din: 8'd0, lst: 1'b0, len: value,
			typed: 1'b0, want: '0};
		plan.push_back(row);
	endtask

	// Result checker and receiver stalls.
	always @(posedge clk) begin
		rc4_res_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_res.size() == 0) begin
				$display("%0t: result with none expected: data=%h status=%0d last=%b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				w = expected_res.pop_front();
				if (m_tdata !== w.data) begin
					$display("%0t: data mismatch: expected %h, actual %h",
						$time, w.data, m_tdata);
					errors++;
				end
				if (m_tuser !== w.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, w.status, m_tuser);
					errors++;
				end
				if (m_tlast !== w.last) begin
					$display("%0t: last mismatch: expected %b, actual %b",
						$time, w.last, m_tlast);
					errors++;
				end
			end
		end
		if (stall_left == 0) begin
			stall_left = pick_idle();
		end
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_rc4_stream_cipher_core: FAIL");
			$finish;
		end
	end

	// Stimulus: directed table first, then random phases.
	initial begin
		logic [8:0] new_len;
		logic [8:0] eff;
		int phase;
		int r;
		int need;
		int nbytes;
		int n;
		int m;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tuser = FUNC_KEY;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		errors = 0;
		items_sent = 0;
		cycles = 0;
		stall_left = 0;
		quiet = 1'b0;
		ks_i = 8'd0;
		ks_j = 8'd0;
		kcount = 9'd0;
		have_key = 1'b0;
		key_len = KeyLenReset;
		for (n = 0; n < 256; n++) begin
			perm[n] = 8'd0;
			kstore[n] = 8'd0;
		end

		// Data before any key is refused.
		add_item(FUNC_DATA, 8'hFF, 1'b1, 1'b1, ST_NO_KEY);
		add_item(FUNC_DATA, 8'h00, 1'b0, 1'b1, ST_NO_KEY);
		// A full key at the reset length, bytes from 00 to FF.
		for (n = 0; n < 16; n++) begin
			add_item(FUNC_KEY, 8'(n * 17), n[0], 1'b1,
				(n == 15) ? ST_SCHED_DONE : ST_KEY_STORED);
		end
		add_item(FUNC_DATA, 8'h00, 1'b0, 1'b0, ST_DATA_DONE);
		add_item(FUNC_DATA, 8'hFF, 1'b1, 1'b0, ST_DATA_DONE);
		// A zero key length counts as one.
		add_keylen(9'd0);
		add_item(FUNC_KEY, 8'hFF, 1'b1, 1'b1, ST_SCHED_DONE);
		add_item(FUNC_DATA, 8'h3C, 1'b1, 1'b0, ST_DATA_DONE);
		// A new key while keyed leaves the old keystream in use.
		add_keylen(9'd3);
		add_item(FUNC_KEY, 8'h12, 1'b0, 1'b1, ST_KEY_STORED);
		add_item(FUNC_DATA, 8'hA5, 1'b0, 1'b0, ST_DATA_DONE);
		add_item(FUNC_KEY, 8'h00, 1'b1, 1'b1, ST_KEY_STORED);
		// Shrinking the length mid-load schedules on the next key byte.
		add_keylen(9'd1);
		add_item(FUNC_KEY, 8'h34, 1'b0, 1'b1, ST_SCHED_DONE);
		add_item(FUNC_DATA, 8'hFF, 1'b1, 1'b0, ST_DATA_DONE);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_KEYLEN) begin
				write_key_len(plan[k].len);
			end else begin
				send_item(plan[k].func, plan[k].din, plan[k].lst, plan[k].typed,
					plan[k].want);
			end
		end

		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			quiet = ($urandom_range(0, 5) == 0);
			// Pick the key length: extremes first, mostly short keys afterwards.
			case (phase)
				0: new_len = 9'd511;
				1: new_len = 9'd256;
				2: new_len = 9'd0;
				3: new_len = 9'd1;
				default: begin
					r = $urandom_range(0, 99);
					if (r < 70) begin
						new_len = 9'($urandom_range(1, 8));
					end else if (r < 85) begin
						new_len = 9'($urandom_range(9, 32));
					end else if (r < 95) begin
						new_len = 9'd16;
					end else if (r < 98) begin
						new_len = 9'($urandom_range(33, 200));
					end else begin
						new_len = 9'($urandom_range(257, 510));
					end
				end
			endcase
			if (phase < 4 || $urandom_range(0, 4) != 0) begin
				write_key_len(new_len);
			end
			eff = key_len_eff();
			r = (phase == 0) ? 0 : $urandom_range(0, 99);
			if (r < 70) begin
				// Complete the key, then a few messages.
				need = (kcount >= eff) ? 1 : int'(eff) - int'(kcount);
				repeat (need) send_random(FUNC_KEY, 1'($urandom));
				repeat ($urandom_range(1, 3)) begin
					nbytes = $urandom_range(1, 40);
					for (m = 0; m < nbytes; m++) begin
						send_random(FUNC_DATA, m == nbytes - 1);
					end
				end
			end else if (r < 85) begin
				// Noise: kinds and marks at random.
				repeat ($urandom_range(1, 20)) send_random(1'($urandom), 1'($urandom));
			end else begin
				// Broken load: a partial key followed by data.
				if (int'(eff) > int'(kcount) + 1) begin
					repeat ($urandom_range(1, int'(eff) - int'(kcount) - 1))
						send_random(FUNC_KEY, 1'($urandom));
				end
				repeat ($urandom_range(0, 5)) send_random(FUNC_DATA, 1'($urandom));
			end
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
			end
			phase++;
		end

		quiet = 1'b0;
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_rc4_stream_cipher_core: PASS");
		end else begin
			$display("tb_rc4_stream_cipher_core: FAIL");
		end
		$finish;
	end

endmodule
